@@ hdl/rcg_pkg.sv @@
// Shared types and constants for the Roberts cross gradient block.
`default_nettype none

package rcg_pkg;

    // Default sizes of the frame and of a pixel.
    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 1024;
    localparam int PIXEL_BITS_DEF = 16;

    // Fixed widths of the configuration data and of the gradients.
    localparam int CFG_BITS  = 11;
    localparam int GRAD_BITS = 18;

    // Frame width and height after reset; the size registers hold each minus one.
    localparam int FRAME_SIZE_RESET = 1024;

    // Configuration register indexes.
    typedef enum logic [0:0] {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } cfg_reg_t;

    // Position flags of one pixel, handed from the scan cell to the window cell.
    typedef struct packed {
        logic first_col;
        logic first_row;
        logic last;
    } scan_info_t;

endpackage

`default_nettype wire

@@ hdl/rcg_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module rcg_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // A read and a write to the same address in one cycle return the old data.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

@@ hdl/rcg_scan.sv @@
// Scan cell: column and row position of the incoming pixel within the frame.
`default_nettype none

module rcg_scan #(
    parameter int MAX_WIDTH  = rcg_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = rcg_pkg::MAX_HEIGHT_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          advance,
    input  wire logic [$clog2(MAX_WIDTH)-1:0]  width_last,
    input  wire logic [$clog2(MAX_HEIGHT)-1:0] height_last,
    output logic      [$clog2(MAX_WIDTH)-1:0]  col,
    output rcg_pkg::scan_info_t                info
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);

    logic [CW-1:0] col_reg, col_next;
    logic [RW-1:0] row_reg, row_next;
    logic          row_end;
    logic          col_end;

    // The column wraps once it reaches the last column, also when the width
    // has been lowered below the current column.
    assign col_end = (col_reg >= width_last);
    assign row_end = (row_reg >= height_last);

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (advance)
        begin
            if (col_end)
            begin
                col_next = '0;
                row_next = row_end ? '0 : row_reg + RW'(1);
            end
            else
            begin
                col_next = col_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    assign col            = col_reg;
    assign info.first_col = (col_reg == '0);
    assign info.first_row = (row_reg == '0);
    assign info.last      = col_end && row_end;

endmodule

`default_nettype wire

@@ hdl/rcg_window.sv @@
// Window cell: builds the 2x2 window and computes both gradients.
`default_nettype none

module rcg_window #(
    parameter int PIXEL_BITS = rcg_pkg::PIXEL_BITS_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           load,
    input  wire logic [PIXEL_BITS-1:0]          pixel,
    input  wire rcg_pkg::scan_info_t            info,
    input  wire logic [PIXEL_BITS-1:0]          above_raw,
    input  wire logic                           advance,
    output logic                                busy,
    output logic      [rcg_pkg::GRAD_BITS-1:0]  grad_col,
    output logic      [rcg_pkg::GRAD_BITS-1:0]  grad_row,
    output logic                                frame_end
);

    localparam int GB     = rcg_pkg::GRAD_BITS;
    localparam int CALC_W = (PIXEL_BITS + 2 > GB) ? PIXEL_BITS + 2 : GB;

    logic                      valid_reg, valid_next;
    logic [PIXEL_BITS-1:0]     pixel_reg;
    rcg_pkg::scan_info_t       info_reg;
    logic [PIXEL_BITS-1:0]     left_reg;
    logic [PIXEL_BITS-1:0]     above_left_reg;

    logic [PIXEL_BITS-1:0]     above;
    logic [PIXEL_BITS-1:0]     left;
    logic [PIXEL_BITS-1:0]     above_left;
    logic signed [CALC_W-1:0]  cur_s, above_s, left_s, above_left_s;
    logic signed [CALC_W-1:0]  gc_s, gr_s;

    assign valid_next = load ? 1'b1 : (advance ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg      <= 1'b0;
            left_reg       <= '0;
            above_left_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (advance)
            begin
                left_reg       <= pixel_reg;
                above_left_reg <= above;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            pixel_reg <= pixel;
            info_reg  <= info;
        end
    end

    // Edge replication in the first row and the first column.
    assign above      = info_reg.first_row ? pixel_reg : above_raw;
    assign left       = info_reg.first_col ? pixel_reg : left_reg;
    assign above_left = info_reg.first_col ? above : above_left_reg;

    assign cur_s        = $signed(CALC_W'(pixel_reg));
    assign above_s      = $signed(CALC_W'(above));
    assign left_s       = $signed(CALC_W'(left));
    assign above_left_s = $signed(CALC_W'(above_left));

    assign gc_s = above_s - left_s + cur_s - above_left_s;
    assign gr_s = left_s - above_s + cur_s - above_left_s;

    assign busy      = valid_reg;
    assign grad_col  = gc_s[GB-1:0];
    assign grad_row  = gr_s[GB-1:0];
    assign frame_end = info_reg.last;

endmodule

`default_nettype wire

@@ hdl/roberts_cross_gradient.sv @@
// Top level of the streaming Roberts cross gradient block.
//
// The block takes one pixel per beat in raster order and returns one beat per
// pixel carrying the column and row Roberts cross gradients over the 2x2
// window of current, left, above and above-left pixels, plus a flag on the
// last pixel of each frame. The first row and the first column are edge
// replicated, so the first pixel of every frame always gives zero gradients.
// Both gradients are exact two's complement values, cut to 18 bits. The block
// sustains one pixel per clock while the output is not stalled: a pixel beat
// can then be accepted in every cycle. An accepted pixel is registered in the
// window cell, where the registered read of the line buffer lands at the same
// edge, and then moves into the output register, from which its result beat
// is offered. The line buffer is read and written at the same column in the
// cycle a pixel is accepted, which sets the one-pixel-per-clock figure.
// Pixels move through a row of cells: the scan cell tracks the position in the
// frame and addresses the line buffer, the window cell holds the left and
// above-left pixels and forms the gradients, and the output register hands the
// result downstream and keeps the input side moving while a result waits.
// The frame width and height are written through the configuration port while
// the block is idle; a width or height of zero counts as one, and values above
// the maximum count as the maximum. The line buffer needs no clearing after
// reset, since each entry is written in the first row before its read data is used.
`default_nettype none

module roberts_cross_gradient #(
    parameter int MAX_WIDTH  = rcg_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = rcg_pkg::MAX_HEIGHT_DEF,
    parameter int PIXEL_BITS = rcg_pkg::PIXEL_BITS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,

    input  wire logic                          cfg_wr_en,
    input  wire logic [0:0]                    cfg_index,
    input  wire logic [rcg_pkg::CFG_BITS-1:0]  cfg_data,

    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [PIXEL_BITS-1:0]         pixel,

    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic      [rcg_pkg::GRAD_BITS-1:0] grad_col,
    output logic      [rcg_pkg::GRAD_BITS-1:0] grad_row,
    output logic                               frame_end
);

    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int RW    = $clog2(MAX_HEIGHT);
    localparam int GB    = rcg_pkg::GRAD_BITS;
    localparam int CB    = rcg_pkg::CFG_BITS;
    localparam int WSZ_W = ($clog2(MAX_WIDTH + 1) > CB) ? $clog2(MAX_WIDTH + 1) : CB;
    localparam int HSZ_W = ($clog2(MAX_HEIGHT + 1) > CB) ? $clog2(MAX_HEIGHT + 1) : CB;
    localparam int W_RST = (rcg_pkg::FRAME_SIZE_RESET > MAX_WIDTH) ?
                           MAX_WIDTH : rcg_pkg::FRAME_SIZE_RESET;
    localparam int H_RST = (rcg_pkg::FRAME_SIZE_RESET > MAX_HEIGHT) ?
                           MAX_HEIGHT : rcg_pkg::FRAME_SIZE_RESET;

    // Frame size is kept as the index of the last column and the last row.
    logic [CW-1:0]    width_last_reg, width_last_next;
    logic [RW-1:0]    height_last_reg, height_last_next;
    logic [WSZ_W-1:0] width_ext, width_sat;
    logic [HSZ_W-1:0] height_ext, height_sat;

    logic                   in_accept;
    logic                   win_busy;
    logic                   win_advance;
    logic [CW-1:0]          scan_col;
    rcg_pkg::scan_info_t    scan_info;
    logic [PIXEL_BITS-1:0]  above_raw;
    logic [GB-1:0]          win_grad_col;
    logic [GB-1:0]          win_grad_row;
    logic                   win_frame_end;

    logic                   out_valid_reg, out_valid_next;
    logic [GB-1:0]          grad_col_reg;
    logic [GB-1:0]          grad_row_reg;
    logic                   frame_end_reg;

    // Saturate the written sizes into the supported range.
    assign width_ext  = WSZ_W'(cfg_data);
    assign height_ext = HSZ_W'(cfg_data);
    assign width_sat  = (width_ext == '0) ? WSZ_W'(1) :
                        (width_ext > WSZ_W'(MAX_WIDTH)) ? WSZ_W'(MAX_WIDTH) : width_ext;
    assign height_sat = (height_ext == '0) ? HSZ_W'(1) :
                        (height_ext > HSZ_W'(MAX_HEIGHT)) ? HSZ_W'(MAX_HEIGHT) : height_ext;

    always_comb
    begin
        width_last_next  = width_last_reg;
        height_last_next = height_last_reg;
        if (cfg_wr_en)
        begin
            unique case (rcg_pkg::cfg_reg_t'(cfg_index))
                rcg_pkg::REG_FRAME_WIDTH:
                begin
                    width_last_next = CW'(width_sat - WSZ_W'(1));
                end
                rcg_pkg::REG_FRAME_HEIGHT:
                begin
                    height_last_next = RW'(height_sat - HSZ_W'(1));
                end
                default:
                begin
                    width_last_next = width_last_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_last_reg  <= CW'(W_RST - 1);
            height_last_reg <= RW'(H_RST - 1);
        end
        else
        begin
            width_last_reg  <= width_last_next;
            height_last_reg <= height_last_next;
        end
    end

    // The window cell moves its result on when the output register is free or
    // is being emptied in this cycle; the input side stalls only when the
    // window cell holds a result that cannot move.
    assign win_advance = win_busy && (!out_valid_reg || !out_stall);
    assign in_stall    = win_busy && !win_advance;
    assign in_accept   = in_valid && !in_stall;

    rcg_scan #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_scan (
        .clk         (clk),
        .rst_n       (rst_n),
        .advance     (in_accept),
        .width_last  (width_last_reg),
        .height_last (height_last_reg),
        .col         (scan_col),
        .info        (scan_info)
    );

    // The previous row: read and overwritten at the same column on every beat.
    rcg_ram #(
        .WIDTH (PIXEL_BITS),
        .DEPTH (MAX_WIDTH)
    ) u_line (
        .clk     (clk),
        .wr_en   (in_accept),
        .wr_addr (scan_col),
        .wr_data (pixel),
        .rd_en   (in_accept),
        .rd_addr (scan_col),
        .rd_data (above_raw)
    );

    rcg_window #(
        .PIXEL_BITS (PIXEL_BITS)
    ) u_window (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (in_accept),
        .pixel     (pixel),
        .info      (scan_info),
        .above_raw (above_raw),
        .advance   (win_advance),
        .busy      (win_busy),
        .grad_col  (win_grad_col),
        .grad_row  (win_grad_row),
        .frame_end (win_frame_end)
    );

    // Output register.
    assign out_valid_next = win_advance ? 1'b1 : (out_stall ? out_valid_reg : 1'b0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (win_advance)
        begin
            grad_col_reg  <= win_grad_col;
            grad_row_reg  <= win_grad_row;
            frame_end_reg <= win_frame_end;
        end
    end

    assign out_valid = out_valid_reg;
    assign grad_col  = grad_col_reg;
    assign grad_row  = grad_row_reg;
    assign frame_end = frame_end_reg;

endmodule

`default_nettype wire

@@ hdl/rcg_checker.sv @@
// Port-level checks for the Roberts cross gradient block, bound to its top level.
`default_nettype none

module rcg_checker (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_stall,
    input  wire logic                          out_valid,
    input  wire logic                          out_stall,
    input  wire logic [rcg_pkg::GRAD_BITS-1:0] grad_col,
    input  wire logic [rcg_pkg::GRAD_BITS-1:0] grad_row,
    input  wire logic                          frame_end
);

    logic frame_start_reg, frame_start_next;

    // Set while the next result beat is the first pixel of a frame.
    assign frame_start_next = (out_valid && !out_stall) ? frame_end : frame_start_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_start_reg <= 1'b1;
        end
        else
        begin
            frame_start_reg <= frame_start_next;
        end
    end

    a_out_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result beat dropped while stalled");

    a_out_payload_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=>
            $stable(grad_col) && $stable(grad_row) && $stable(frame_end))
        else $error("stalled result beat changed");

    // Both gradients differ by twice a pixel difference, so their parity matches.
    a_grad_parity: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> grad_col[0] == grad_row[0])
        else $error("gradient parity mismatch");

    a_frame_start_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_start_reg |-> grad_col == '0 && grad_row == '0)
        else $error("first pixel of a frame gave a nonzero gradient");

    // The input side only backs up when a result is waiting downstream.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled with the output free");

endmodule

bind roberts_cross_gradient rcg_checker u_rcg_checker (.*);

`default_nettype wire
